/* design/rrwl_pkg.sv */
`default_nettype none
package rrwl_pkg;

  localparam int REQUESTERS_DEF = 16;
  localparam int MAX_NEST_DEF   = 255;

  localparam int OP_W     = 2;
  localparam int REQ_W    = 4;
  localparam int ST_W     = 2;
  localparam int TOTAL_W  = 12;
  // wide enough to compare a requester number against any supported count
  localparam int REQ_EXT_W = 9;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [OP_W-1:0] OP_ACQ_RD = 2'd0;
  localparam logic [OP_W-1:0] OP_ACQ_WR = 2'd1;
  localparam logic [OP_W-1:0] OP_REL_RD = 2'd2;
  localparam logic [OP_W-1:0] OP_REL_WR = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_WAIT      = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_OWNER = 2'd2;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd3;

  // classified request held in the queue
  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [REQ_W-1:0] requester;
    logic             in_range;
  } req_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

endpackage
`default_nettype wire

/* design/rrwl_front.sv */
`default_nettype none
module rrwl_front import rrwl_pkg::*; #(
  parameter int REQUESTERS = REQUESTERS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [OP_W-1:0]  in_opcode,
  input  wire logic [REQ_W-1:0] in_requester,
  output q_head_t               head,
  input  wire logic             pop
);

  localparam int QDEPTH = 2;

  req_t             q_mem_r [QDEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             push;
  req_t             req_in;
  logic [REQ_EXT_W-1:0] req_ext;

  // range check against the configured requester count
  always_comb begin
    req_ext          = REQ_EXT_W'(in_requester);
    req_in.opcode    = in_opcode;
    req_in.requester = in_requester;
    req_in.in_range  = req_ext < REQ_EXT_W'(REQUESTERS);
  end

  assign in_stall = (count_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;

  assign head.valid = (count_r != 2'd0);
  assign head.req   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/rrwl_back.sv */
`default_nettype none
module rrwl_back import rrwl_pkg::*; #(
  parameter int REQUESTERS = REQUESTERS_DEF,
  parameter int MAX_NEST   = MAX_NEST_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire q_head_t head,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [ST_W-1:0] out_status,
  output logic        out_held_any,
  output logic        out_held_for_write,
  output logic        out_wake_waiters
);

  localparam int IDX_W = $clog2(REQUESTERS);
  localparam int HC_W  = $clog2(MAX_NEST + 1);
  localparam logic [HC_W-1:0] NEST_LIM = HC_W'(MAX_NEST);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                 state_r, state_nxt;
  req_t                 cur_r;
  logic [HC_W-1:0]      hc_mem [REQUESTERS];
  logic [REQUESTERS-1:0] vld_r;
  logic [HC_W-1:0]      rd_data_r;
  logic                 rd_vld_r;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic                 wm_r, wm_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]      out_status_r;
  logic                 out_any_r, out_wr_r, out_wake_r;

  logic [IDX_W-1:0]     rd_idx, cur_idx;
  logic [HC_W-1:0]      hc, hc_nxt;
  logic [ST_W-1:0]      st;
  logic                 wake, can_nest, is_acq, commit, out_free;

  always_comb begin
    rd_idx  = IDX_W'(REQ_EXT_W'(head.req.requester));
    cur_idx = IDX_W'(REQ_EXT_W'(cur_r.requester));
  end

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == S_IDLE) && head.valid;
  assign commit   = (state_r == S_EXEC) && out_free;

  // lock decision on the registered count of the current requester
  always_comb begin
    hc        = rd_vld_r ? rd_data_r : '0;
    hc_nxt    = hc;
    total_nxt = total_r;
    wm_nxt    = wm_r;
    st        = ST_OK;
    wake      = 1'b0;
    is_acq    = (cur_r.opcode == OP_ACQ_RD) || (cur_r.opcode == OP_ACQ_WR);
    can_nest  = (hc < NEST_LIM) && (total_r < TOTAL_MAX);
    if (!cur_r.in_range) begin
      st = ST_NOT_OWNER;
    end else if (is_acq) begin
      if (hc == '0 && ((cur_r.opcode == OP_ACQ_RD) ? wm_r : (total_r != '0))) begin
        st = ST_WAIT;
      end else if (!can_nest) begin
        st = ST_OVERFLOW;
      end else begin
        hc_nxt    = hc + HC_W'(1);
        total_nxt = total_r + TOTAL_W'(1);
        if (cur_r.opcode == OP_ACQ_WR) begin
          wm_nxt = 1'b1;
        end
      end
    end else if (cur_r.opcode == OP_REL_WR && !wm_r) begin
      st = ST_NOT_OWNER;
    end else if (hc == '0) begin
      st = ST_NOT_OWNER;
    end else begin
      hc_nxt = hc - HC_W'(1);
      if (total_r != '0) begin
        total_nxt = total_r - TOTAL_W'(1);
      end
      if (total_nxt == '0) begin
        wm_nxt = 1'b0;
        wake   = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // per-requester count memory, registered read
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r <= hc_mem[rd_idx];
    end
    if (commit && cur_r.in_range) begin
      hc_mem[cur_idx] <= hc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head.req;
    end
    if (commit) begin
      out_status_r <= st;
      out_any_r    <= (total_nxt != '0);
      out_wr_r     <= wm_nxt;
      out_wake_r   <= wake;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      total_r     <= '0;
      wm_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        rd_vld_r <= vld_r[rd_idx];
      end
      if (commit) begin
        total_r <= total_nxt;
        wm_r    <= wm_nxt;
        if (cur_r.in_range) begin
          vld_r[cur_idx] <= 1'b1;
        end
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_held_any       = out_any_r;
  assign out_held_for_write = out_wr_r;
  assign out_wake_waiters   = out_wake_r;

  a_wm_needs_holder: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r == '0) |-> !wm_r)
    else $error("write mode set with no holders");

  a_wake_only_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    commit && wake |-> (st == ST_OK) && (total_nxt == '0) && !is_acq)
    else $error("wake raised outside a final release");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !pop)
    else $error("queue popped while a request is in progress");

  a_total_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> total_r == $past(total_r))
    else $error("hold total changed without a committed request");

endmodule
`default_nettype wire

/* design/reentrant_reader_writer_lock_core.sv */
// Lock manager for one reentrant reader-writer lock. Each request
// (in_opcode: acquire read, acquire write, release read, release write;
// in_requester: the requesting master) yields exactly one result with a
// status (granted, wait and retry, not owner, overflow) plus the lock's
// held and write-mode flags after the request and a wake flag when a
// release frees the lock completely. A holder nests while below the nest
// and total limits and an acquire-write from a holder upgrades to write
// mode. Requests enter a two-deep queue; the back end takes one request
// at a time in two steps, first reading the requester's hold count from
// the count memory, then deciding and writing it back, and pops the next
// request only after the result is registered; a stall on the result side
// holds it in the second step. Counts reset to zero at once through
// per-entry valid bits, so no clearing pass is needed.
`default_nettype none
module reentrant_reader_writer_lock_core import rrwl_pkg::*; #(
  parameter int REQUESTERS = REQUESTERS_DEF,
  parameter int MAX_NEST   = MAX_NEST_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [OP_W-1:0]  in_opcode,
  input  wire logic [REQ_W-1:0] in_requester,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [ST_W-1:0]       out_status,
  output logic                  out_held_any,
  output logic                  out_held_for_write,
  output logic                  out_wake_waiters
);

  // queue head and pop between front and back
  q_head_t head;
  logic    pop;

  // front: accepts each request, range-checks the requester, queues it
  rrwl_front #(
    .REQUESTERS(REQUESTERS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_requester(in_requester),
    .head        (head),
    .pop         (pop)
  );

  // back: count lookup, lock decision, state update, result register
  rrwl_back #(
    .REQUESTERS(REQUESTERS),
    .MAX_NEST  (MAX_NEST)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_held_any      (out_held_any),
    .out_held_for_write(out_held_for_write),
    .out_wake_waiters  (out_wake_waiters)
  );

endmodule
`default_nettype wire

/* test/tb_reentrant_reader_writer_lock_core.sv */
`default_nettype none
module tb_reentrant_reader_writer_lock_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rrwl_pkg::*;

  // lock geometry as the block is built here
  localparam int LOCK_USERS    = REQUESTERS_DEF;
  localparam int LOCK_NEST_MAX = MAX_NEST_DEF;
  // random request count and the quiet stretch at the end
  localparam int RANDOM_REQUESTS = 700;
  localparam int QUIET_TAIL      = 150;

  // one answer of the lock: status plus the flags after the request
  typedef struct packed {
    logic [ST_W-1:0] status;
    logic            held_any;
    logic            held_for_write;
    logic            wake;
  } lock_result_t;

  // one row of the directed plan, sent reps times in a row
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [REQ_W-1:0] who;
    logic [8:0]       reps;
    logic             typed;
    lock_result_t     want;
  } plan_row_t;

  localparam lock_result_t NOT_TYPED = '0;

  // typed answers only where they are obvious, the rest comes from the lock predictor
  localparam plan_row_t DIRECTED_PLAN [26] = '{
    // releases on an idle lock are refused
    '{OP_REL_RD, 4'd0,  9'd1, 1'b1, '{ST_NOT_OWNER, 1'b0, 1'b0, 1'b0}},
    '{OP_REL_WR, 4'd15, 9'd1, 1'b1, '{ST_NOT_OWNER, 1'b0, 1'b0, 1'b0}},
    // two readers, a writer must wait
    '{OP_ACQ_RD, 4'd0,  9'd1, 1'b1, '{ST_OK,        1'b1, 1'b0, 1'b0}},
    '{OP_ACQ_RD, 4'd15, 9'd1, 1'b1, '{ST_OK,        1'b1, 1'b0, 1'b0}},
    '{OP_ACQ_WR, 4'd5,  9'd1, 1'b1, '{ST_WAIT,      1'b1, 1'b0, 1'b0}},
    // a reader upgrades while another reader still holds the lock
    '{OP_ACQ_WR, 4'd0,  9'd1, 1'b1, '{ST_OK,        1'b1, 1'b1, 1'b0}},
    '{OP_ACQ_RD, 4'd7,  9'd1, 1'b1, '{ST_WAIT,      1'b1, 1'b1, 1'b0}},
    // release write by a plain reader while in write mode
    '{OP_REL_WR, 4'd15, 9'd1, 1'b1, '{ST_OK,        1'b1, 1'b1, 1'b0}},
    '{OP_REL_WR, 4'd15, 9'd1, 1'b1, '{ST_NOT_OWNER, 1'b1, 1'b1, 1'b0}},
    '{OP_REL_RD, 4'd0,  9'd1, 1'b0, NOT_TYPED},
    // last release clears write mode and wakes waiters
    '{OP_REL_WR, 4'd0,  9'd1, 1'b1, '{ST_OK,        1'b0, 1'b0, 1'b1}},
    // writer nests in both modes, others are held off
    '{OP_ACQ_WR, 4'd9,  9'd1, 1'b1, '{ST_OK,        1'b1, 1'b1, 1'b0}},
    '{OP_ACQ_WR, 4'd9,  9'd1, 1'b0, NOT_TYPED},
    '{OP_ACQ_RD, 4'd9,  9'd1, 1'b0, NOT_TYPED},
    '{OP_ACQ_RD, 4'd2,  9'd1, 1'b1, '{ST_WAIT,      1'b1, 1'b1, 1'b0}},
    '{OP_REL_RD, 4'd2,  9'd1, 1'b1, '{ST_NOT_OWNER, 1'b1, 1'b1, 1'b0}},
    '{OP_REL_RD, 4'd9,  9'd3, 1'b0, NOT_TYPED},
    // nest one reader up to the limit, then overflow in both modes
    '{OP_ACQ_RD, 4'd4,  9'd255, 1'b0, NOT_TYPED},
    '{OP_ACQ_RD, 4'd4,  9'd1, 1'b1, '{ST_OVERFLOW,  1'b1, 1'b0, 1'b0}},
    '{OP_ACQ_WR, 4'd4,  9'd1, 1'b1, '{ST_OVERFLOW,  1'b1, 1'b0, 1'b0}},
    // release write outside write mode is refused
    '{OP_ACQ_RD, 4'd6,  9'd1, 1'b1, '{ST_OK,        1'b1, 1'b0, 1'b0}},
    '{OP_REL_WR, 4'd6,  9'd1, 1'b1, '{ST_NOT_OWNER, 1'b1, 1'b0, 1'b0}},
    '{OP_REL_RD, 4'd6,  9'd1, 1'b0, NOT_TYPED},
    '{OP_REL_RD, 4'd4,  9'd255, 1'b0, NOT_TYPED},
    '{OP_ACQ_WR, 4'd15, 9'd1, 1'b1, '{ST_OK,        1'b1, 1'b1, 1'b0}},
    '{OP_REL_WR, 4'd15, 9'd1, 1'b1, '{ST_OK,        1'b0, 1'b0, 1'b1}}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [OP_W-1:0]  in_opcode;
  logic [REQ_W-1:0] in_requester;
  logic             out_valid;
  logic             out_stall;
  logic [ST_W-1:0]  out_status;
  logic             out_held_any;
  logic             out_held_for_write;
  logic             out_wake_waiters;

  reentrant_reader_writer_lock_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_requester       (in_requester),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_held_any       (out_held_any),
    .out_held_for_write (out_held_for_write),
    .out_wake_waiters   (out_wake_waiters)
  );

  // predictor copy of the lock state
  logic [7:0]         lock_holds [LOCK_USERS];
  logic [TOTAL_W-1:0] lock_total;
  logic               lock_write_mode;

  // answers still owed by the block, oldest first
  lock_result_t pending_answers [$];

  int  mismatches;
  int  requests_sent;
  int  answers_checked;
  int  status_tally [4];
  int  wake_tally;
  bit  sender_idles;
  bit  quiet_tail;

  // clock, 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL reentrant_reader_writer_lock_core");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // a requester can nest once more only below both limits
  function automatic bit room_to_nest(input int id);
    return lock_holds[id] < LOCK_NEST_MAX && lock_total != TOTAL_MAX;
  endfunction

  // advance the lock predictor by one request and return its answer
  function automatic lock_result_t predict_lock_step(input logic [OP_W-1:0] op,
                                                    input logic [REQ_W-1:0] who);
    lock_result_t ans;
    int id;
    ans = '{ST_OK, 1'b0, 1'b0, 1'b0};
    id = int'(who);
    if (id >= LOCK_USERS) begin
      ans.status = ST_NOT_OWNER;
    end else if (op == OP_ACQ_RD || op == OP_ACQ_WR) begin
      if (lock_holds[id] != 0) begin
        // holders nest while there is room, a write request upgrades
        if (!room_to_nest(id)) begin
          ans.status = ST_OVERFLOW;
        end else begin
          lock_holds[id]++;
          lock_total++;
          if (op == OP_ACQ_WR) lock_write_mode = 1'b1;
        end
      end else if (op == OP_ACQ_RD ? lock_write_mode : (lock_total != 0)) begin
        ans.status = ST_WAIT;
      end else if (!room_to_nest(id)) begin
        ans.status = ST_OVERFLOW;
      end else begin
        lock_holds[id] = 8'd1;
        lock_total++;
        if (op == OP_ACQ_WR) lock_write_mode = 1'b1;
      end
    end else if (op == OP_REL_WR && !lock_write_mode) begin
      ans.status = ST_NOT_OWNER;
    end else if (lock_holds[id] == 0) begin
      ans.status = ST_NOT_OWNER;
    end else begin
      // release write after an upgrade counts down like a read release
      lock_holds[id]--;
      if (lock_total != 0) lock_total--;
      if (lock_total == 0) begin
        lock_write_mode = 1'b0;
        ans.wake = 1'b1;
      end
    end
    ans.held_any = (lock_total != 0);
    ans.held_for_write = lock_write_mode;
    return ans;
  endfunction

  // present one request, hold it until taken, then log what it must answer
  task automatic send_request(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] who,
                              input logic typed, input lock_result_t want);
    lock_result_t predicted;
    if (sender_idles && !quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_requester <= who;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // taken at this edge, predictor runs in request order
    predicted = predict_lock_step(op, who);
    pending_answers.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  // random holder, or -1 when the lock is free
  function automatic int pick_holder();
    int ids [$];
    for (int i = 0; i < LOCK_USERS; i++) begin
      if (lock_holds[i] != 0) ids.push_back(i);
    end
    if (ids.size() == 0) return -1;
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  // mostly well-formed lock traffic shaped by the current lock state
  task automatic pick_request(input int release_pct, output logic [OP_W-1:0] op,
                              output logic [REQ_W-1:0] who);
    int holder;
    holder = pick_holder();
    if ($urandom_range(0, 99) < 12) begin
      // noise: anything at all
      op  = OP_W'($urandom_range(0, 3));
      who = REQ_W'($urandom_range(0, LOCK_USERS - 1));
    end else if (holder >= 0 && $urandom_range(0, 99) < release_pct) begin
      who = REQ_W'(holder);
      op  = (lock_write_mode && $urandom_range(0, 1) == 1) ? OP_REL_WR : OP_REL_RD;
    end else begin
      if (holder >= 0 && $urandom_range(0, 99) < 40) who = REQ_W'(holder);
      else who = REQ_W'($urandom_range(0, LOCK_USERS - 1));
      op = ($urandom_range(0, 3) == 0) ? OP_ACQ_WR : OP_ACQ_RD;
    end
  endtask

  // release every hold so the next phase starts on a free lock
  task automatic drain_lock();
    int holder;
    holder = pick_holder();
    while (holder >= 0) begin
      send_request(OP_REL_RD, REQ_W'(holder), 1'b0, NOT_TYPED);
      holder = pick_holder();
    end
  endtask

  // result side back-pressure in random bursts
  initial begin
    out_stall <= 1'b0;
    repeat (12) @(posedge clk);
    forever begin
      if (quiet_tail) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 15) == 0) begin
        // a stretch with no stall at all
        out_stall <= 1'b0;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  // compare every taken result with the oldest owed answer
  always @(posedge clk) begin
    lock_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("results with no request waiting", 1, 0);
      end else begin
        want = pending_answers.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", int'(out_status), int'(want.status));
        if (out_held_any !== want.held_any)
          report_mismatch("held_any", int'(out_held_any), int'(want.held_any));
        if (out_held_for_write !== want.held_for_write)
          report_mismatch("held_for_write", int'(out_held_for_write),
                          int'(want.held_for_write));
        if (out_wake_waiters !== want.wake)
          report_mismatch("wake_waiters", int'(out_wake_waiters), int'(want.wake));
        status_tally[want.status]++;
        if (want.wake) wake_tally++;
        answers_checked++;
      end
    end
  end

  // stimulus
  initial begin
    logic [OP_W-1:0]  op;
    logic [REQ_W-1:0] who;
    int release_pct;
    int nest_len;
    int nest_who;

    in_valid     <= 1'b0;
    in_opcode    <= OP_ACQ_RD;
    in_requester <= '0;
    rst_n        <= 1'b0;
    mismatches      = 0;
    requests_sent   = 0;
    answers_checked = 0;
    wake_tally      = 0;
    status_tally    = '{0, 0, 0, 0};
    sender_idles    = 1'b1;
    quiet_tail      = 1'b0;
    release_pct     = 50;
    for (int i = 0; i < LOCK_USERS; i++) lock_holds[i] = '0;
    lock_total      = '0;
    lock_write_mode = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed plan
    foreach (DIRECTED_PLAN[i]) begin
      repeat (DIRECTED_PLAN[i].reps)
        send_request(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].who,
                     DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
    end

    // random traffic in phases with their own release pressure
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 0) release_pct = $urandom_range(25, 65);
      if (n % 100 == 0) sender_idles = ($urandom_range(0, 3) != 0);
      if (n == RANDOM_REQUESTS - QUIET_TAIL) quiet_tail = 1'b1;

      // sender holds off until the block has answered everything
      if (n == RANDOM_REQUESTS / 2) begin
        in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        @(posedge clk);
      end

      // one deep nest from a random requester, from 4 below to 4 past the nest limit
      if (n == 200) begin
        drain_lock();
        nest_who = $urandom_range(0, LOCK_USERS - 1);
        nest_len = $urandom_range(LOCK_NEST_MAX - 4, LOCK_NEST_MAX + 4);
        repeat (nest_len)
          send_request(($urandom_range(0, 7) == 0) ? OP_ACQ_WR : OP_ACQ_RD,
                       REQ_W'(nest_who), 1'b0, NOT_TYPED);
        drain_lock();
      end

      pick_request(release_pct, op, who);
      send_request(op, who, 1'b0, NOT_TYPED);
    end
    in_valid <= 1'b0;

    // let every owed answer come back, then watch for strays
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("run covered %0d requests, %0d answers checked, %0d lock releases woke waiters",
             requests_sent, answers_checked, wake_tally);
    $display("answers by status: granted %0d, wait %0d, not owner %0d, overflow %0d",
             status_tally[ST_OK], status_tally[ST_WAIT], status_tally[ST_NOT_OWNER],
             status_tally[ST_OVERFLOW]);
    if (mismatches == 0) begin
      $display("PASS reentrant_reader_writer_lock_core");
    end else begin
      $display("FAIL reentrant_reader_writer_lock_core");
    end
    $finish;
  end

endmodule
`default_nettype wire
